// File: hdl/sswem_pkg.sv
// Types, constants and helpers shared by the stereo window energy meter.
`timescale 1ns / 1ps

package sswem_pkg;

	localparam int SAMPLE_W = 24;
	localparam int MAG_W    = 24;
	localparam int SQ_W     = 2 * MAG_W - 1;
	localparam int SUM_W    = 62;
	localparam int TOTAL_W  = 64;
	localparam int COUNT_W  = 48;
	localparam int WL_W     = 16;
	localparam int QDEPTH   = 8;
	localparam int QPTR_W   = 3;
	localparam int QCNT_W   = QPTR_W + 1;

	localparam logic [WL_W-1:0] WL_RESET = 16'd14400;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [MAG_W-1:0]           mag_t;
	typedef logic [SQ_W-1:0]            sq_t;
	typedef logic [SUM_W-1:0]           sum_t;
	typedef logic [TOTAL_W-1:0]         total_t;
	typedef logic [COUNT_W-1:0]         count_t;

	localparam sum_t SUM_LIMIT = '1;

	typedef struct packed {
		logic valid;
		logic restart;
		logic full;
	} chan_ctl_t;

	typedef struct packed {
		sum_t   sum;
		sum_t   max;
		mag_t   peak;
		total_t total;
	} chan_stats_t;

	typedef struct packed {
		chan_stats_t left;
		chan_stats_t right;
		count_t      count;
		logic        window_full;
	} result_t;

	function automatic mag_t magnitude(input sample_t s);
		mag_t m;
		m = mag_t'(s);
		if (s[SAMPLE_W-1]) begin
			m = ~m + mag_t'(1);
		end
		return m;
	endfunction

endpackage

// File: hdl/sswem_if.sv
// Valid/ready channel interfaces for sample input and statistics output.
`timescale 1ns / 1ps

interface sswem_in_if import sswem_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t left_sample;
	sample_t right_sample;
	logic    restart;

	modport source (output valid, output left_sample, output right_sample, output restart,
		input ready);
	modport sink (input valid, input left_sample, input right_sample, input restart,
		output ready);
endinterface

interface sswem_out_if import sswem_pkg::*; ();
	logic   valid;
	logic   ready;
	sum_t   left_window_energy;
	sum_t   right_window_energy;
	sum_t   left_max_window_energy;
	sum_t   right_max_window_energy;
	mag_t   left_peak;
	mag_t   right_peak;
	total_t left_total_energy;
	total_t right_total_energy;
	count_t samples_seen;
	logic   window_full;

	modport source (output valid, output left_window_energy, output right_window_energy,
		output left_max_window_energy, output right_max_window_energy,
		output left_peak, output right_peak, output left_total_energy,
		output right_total_energy, output samples_seen, output window_full,
		input ready);
	modport sink (input valid, input left_window_energy, input right_window_energy,
		input left_max_window_energy, input right_max_window_energy,
		input left_peak, input right_peak, input left_total_energy,
		input right_total_energy, input samples_seen, input window_full,
		output ready);
endinterface

// File: hdl/sswem_ram.sv
// Generic simple dual-port RAM, read-first, registered read.
`timescale 1ns / 1ps

module sswem_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/sswem_chan.sv
// Per-channel statistics pipeline: squares, window sum, max, peak, total.
`timescale 1ns / 1ps

module sswem_chan import sswem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  chan_ctl_t   ctl_s1,
	input  sample_t     sample_s1,
	input  sample_t     old_sample_s1,
	output chan_stats_t stats_s4
);
	mag_t                   mag_new, mag_old;
	logic [2*MAG_W-1:0]     prod_new, prod_old;
	sq_t                    sq_s2, osq_s2, sq_s3, osq_s3;
	mag_t                   mag_s2;
	logic                   valid_s2, valid_s3, valid_s4;
	logic                   rst_s2, rst_s3, rst_s4;
	logic signed [SQ_W:0]   diff_s2, diff_s3;
	mag_t                   peak_q, peak_base, peak_s4;
	total_t                 total_q, total_base, total_next, total_s4;
	logic [TOTAL_W:0]       total_add;
	sum_t                   sum_q, sum_base, sum_next;
	logic signed [SUM_W+1:0] sum_add;
	sum_t                   max_q, max_base, max_next;

	// s1: magnitudes and squares
	assign mag_new  = magnitude(sample_s1);
	assign mag_old  = magnitude(old_sample_s1);
	assign prod_new = mag_new * mag_new;
	assign prod_old = mag_old * mag_old;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= ctl_s1.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		rst_s2  <= ctl_s1.restart;
		sq_s2   <= prod_new[SQ_W-1:0];
		osq_s2  <= ctl_s1.full ? prod_old[SQ_W-1:0] : '0;
		mag_s2  <= mag_new;
		rst_s3  <= rst_s2;
		sq_s3   <= sq_s2;
		osq_s3  <= osq_s2;
		diff_s3 <= diff_s2;
		rst_s4  <= rst_s3;
		peak_s4 <= peak_q;
		total_s4 <= total_q;
	end

	// s2: peak, total, square difference
	assign diff_s2    = $signed({1'b0, sq_s2}) - $signed({1'b0, osq_s2});
	assign peak_base  = rst_s2 ? '0 : peak_q;
	assign total_base = rst_s2 ? '0 : total_q;
	assign total_add  = {1'b0, total_base} + (TOTAL_W+1)'(sq_s2);
	assign total_next = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];

	// s3: window sum; old square leaves as the new one enters
	assign sum_base = rst_s3 ? '0 : sum_q;
	assign sum_add  = $signed({2'b00, sum_base}) + (SUM_W+2)'(diff_s3);
	always_comb begin
		if (sum_base > sum_t'(osq_s3)) begin
			sum_next = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
		end else begin
			sum_next = sum_t'(sq_s3);
		end
	end

	// s4: window max
	assign max_base = rst_s4 ? '0 : max_q;
	assign max_next = (sum_q > max_base) ? sum_q : max_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			total_q <= '0;
			sum_q   <= '0;
			max_q   <= '0;
		end else begin
			if (valid_s2) begin
				peak_q  <= (mag_s2 > peak_base) ? mag_s2 : peak_base;
				total_q <= total_next;
			end
			if (valid_s3) begin
				sum_q <= sum_next;
			end
			if (valid_s4) begin
				max_q <= max_next;
			end
		end
	end

	assign stats_s4 = '{sum: sum_q, max: max_next, peak: peak_s4, total: total_s4};

	a_max_covers_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |=> max_q >= $past(sum_q))
		else $error("window max below window sum");
endmodule

// File: hdl/sswem_outq.sv
// Result queue that decouples the statistics pipeline from the output word.
`timescale 1ns / 1ps

module sswem_outq import sswem_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    valid,
	output result_t head
);
	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign valid  = cnt_q != '0;
	assign do_pop = pop && valid;
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != QCNT_W'(QDEPTH))
		else $error("result queue overflow");
endmodule

// File: hdl/stereo_sliding_window_energy_meter.sv
// Stereo sliding-window energy meter with peak hold, top level.
// Takes one stereo sample word per clock while samples.ready is high and
// returns one statistics word per sample word, in order. The history memory
// is read at the same edge that takes the sample. The stages are the squares,
// then peak and total, the window sum, and the window max. The history memory
// holds MAX_WINDOW raw stereo samples; each accepted word writes the new
// sample and reads the one leaving the window. An eight-word result queue with
// credit count lets input run at one word per cycle while results are taken,
// and holds input off only when eight words are outstanding. window_length is
// clamped to 1..MAX_WINDOW; change it only with the pipeline empty, and send
// restart with the next sample for exact window sums.
`timescale 1ns / 1ps

module stereo_sliding_window_energy_meter import sswem_pkg::*; #(
	parameter int MAX_WINDOW = 32768
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WL_W-1:0]   cfg_wdata,
	sswem_in_if.sink          samples,
	sswem_out_if.source       stats
);
	localparam int PW = $clog2(MAX_WINDOW);
	localparam int WW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (WW > WL_W) ? WW : WL_W;

	logic [WL_W-1:0]   wl_q;
	logic [CW-1:0]     wl_ext, w_clamp;
	logic [WW-1:0]     w;
	logic [PW-1:0]     ptr_q, ptr_b;
	logic [WW-1:0]     fill_q, fill_b, fill_next, ptr_ext;
	count_t            count_q, count_b, count_next;
	logic              full, accept, out_accept;
	logic [PW-1:0]     old_slot;
	logic [2*SAMPLE_W-1:0] hist_rdata;
	logic [QCNT_W-1:0] inflight_q;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic              rst_s1, full_s1;
	sample_t           left_s1, right_s1;
	count_t            count_s1, count_s2, count_s3, count_s4;
	logic              wfull_s1, wfull_s2, wfull_s3, wfull_s4;
	chan_ctl_t         ctl_s1;
	chan_stats_t       left_stats_s4, right_stats_s4;
	result_t           res_s4, res_head;

	assign accept     = samples.valid && samples.ready;
	assign out_accept = stats.valid && stats.ready;
	assign samples.ready = inflight_q < QCNT_W'(QDEPTH);

	// window length clamp
	assign wl_ext = CW'(wl_q);
	always_comb begin
		if (wl_ext == '0) begin
			w_clamp = CW'(1);
		end else if (wl_ext > CW'(MAX_WINDOW)) begin
			w_clamp = CW'(MAX_WINDOW);
		end else begin
			w_clamp = wl_ext;
		end
	end
	assign w = w_clamp[WW-1:0];

	// s0: ring pointer, fill and sample count
	assign ptr_b   = samples.restart ? '0 : ptr_q;
	assign fill_b  = samples.restart ? '0 : fill_q;
	assign count_b = samples.restart ? '0 : count_q;
	assign full    = fill_b >= w;
	assign ptr_ext = WW'(ptr_b);
	assign old_slot = (ptr_ext >= w) ? PW'(ptr_ext - w)
		: PW'(ptr_ext + WW'(MAX_WINDOW) - w);
	assign fill_next  = full ? w : fill_b + WW'(1);
	assign count_next = (count_b == '1) ? count_b : count_b + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q       <= WL_RESET;
			ptr_q      <= '0;
			fill_q     <= '0;
			count_q    <= '0;
			inflight_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
		end else begin
			if (cfg_we) begin
				wl_q <= cfg_wdata;
			end
			if (accept) begin
				ptr_q   <= (ptr_b == PW'(MAX_WINDOW - 1)) ? '0 : ptr_b + PW'(1);
				fill_q  <= fill_next;
				count_q <= count_next;
			end
			inflight_q <= inflight_q + QCNT_W'(accept) - QCNT_W'(out_accept);
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		rst_s1   <= samples.restart;
		full_s1  <= full;
		left_s1  <= samples.left_sample;
		right_s1 <= samples.right_sample;
		count_s1 <= count_next;
		wfull_s1 <= fill_next >= w;
		count_s2 <= count_s1;
		wfull_s2 <= wfull_s1;
		count_s3 <= count_s2;
		wfull_s3 <= wfull_s2;
		count_s4 <= count_s3;
		wfull_s4 <= wfull_s3;
	end

	sswem_ram #(
		.WIDTH(2 * SAMPLE_W),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk  (clk),
		.we   (accept),
		.waddr(ptr_b),
		.wdata({samples.right_sample, samples.left_sample}),
		.re   (accept),
		.raddr(old_slot),
		.rdata(hist_rdata)
	);

	assign ctl_s1 = '{valid: valid_s1, restart: rst_s1, full: full_s1};

	sswem_chan u_left (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.sample_s1    (left_s1),
		.old_sample_s1(sample_t'(hist_rdata[SAMPLE_W-1:0])),
		.stats_s4     (left_stats_s4)
	);

	sswem_chan u_right (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.sample_s1    (right_s1),
		.old_sample_s1(sample_t'(hist_rdata[2*SAMPLE_W-1:SAMPLE_W])),
		.stats_s4     (right_stats_s4)
	);

	assign res_s4 = '{left: left_stats_s4, right: right_stats_s4, count: count_s4,
		window_full: wfull_s4};

	sswem_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s4),
		.push_data(res_s4),
		.pop      (stats.ready),
		.valid    (stats.valid),
		.head     (res_head)
	);

	assign stats.left_window_energy      = res_head.left.sum;
	assign stats.right_window_energy     = res_head.right.sum;
	assign stats.left_max_window_energy  = res_head.left.max;
	assign stats.right_max_window_energy = res_head.right.max;
	assign stats.left_peak               = res_head.left.peak;
	assign stats.right_peak              = res_head.right.peak;
	assign stats.left_total_energy       = res_head.left.total;
	assign stats.right_total_energy      = res_head.right.total;
	assign stats.samples_seen            = res_head.count;
	assign stats.window_full             = res_head.window_full;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= QCNT_W'(QDEPTH))
		else $error("outstanding word count above queue depth");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> inflight_q != '0)
		else $error("result word with nothing outstanding");

	a_restart_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.restart) |=> valid_s1 && !full_s1)
		else $error("restart did not clear window fill");
endmodule

// File: sim/tb.sv
// Self-checking testbench for the stereo sliding-window energy meter.
`timescale 1ns / 1ps

module tb import sswem_pkg::*; ();

	localparam int      HIST_DEPTH = 32768;
	localparam int      HOLD_CYCLES = 64;
	localparam int      WATCHDOG = 2000;
	localparam int      REPORT_MAX = 200;
	localparam sample_t MOST_POS = 24'sh7FFFFF;
	localparam sample_t MOST_NEG = 24'sh800000;

	class energy_scoreboard;
		bit [SAMPLE_W-1:0] history [2][HIST_DEPTH];
		int unsigned       wr_ptr;
		int unsigned       fill;
		logic [WL_W-1:0]   win_len;
		sum_t              win_sum [2];
		sum_t              win_max [2];
		mag_t              peak [2];
		total_t            total [2];
		count_t            count;
		result_t           pending [$];
		int                errors;
		int                reported;

		function new();
			win_len = WL_RESET;
			errors = 0;
			reported = 0;
			clear();
		endfunction

		function void clear();
			wr_ptr = 0;
			fill = 0;
			count = '0;
			for (int ch = 0; ch < 2; ch++) begin
				win_sum[ch] = '0;
				win_max[ch] = '0;
				peak[ch] = '0;
				total[ch] = '0;
			end
		endfunction

		function void set_window(logic [WL_W-1:0] v);
			win_len = v;
		endfunction

		function mag_t abs_of(sample_t s);
			logic signed [SAMPLE_W:0] wide;
			wide = (SAMPLE_W+1)'(s);
			if (wide < 0) begin
				wide = -wide;
			end
			return wide[MAG_W-1:0];
		endfunction

		function void update_channel(int ch, sample_t s, bit full, int unsigned slot);
			mag_t        m;
			mag_t        om;
			logic [63:0] sq;
			logic [63:0] osq;
			logic [64:0] acc;
			m = abs_of(s);
			sq = 64'(m) * 64'(m);
			if (full) begin
				om = abs_of(sample_t'(history[ch][slot]));
				osq = 64'(om) * 64'(om);
				win_sum[ch] = (64'(win_sum[ch]) > osq) ? sum_t'(64'(win_sum[ch]) - osq) : '0;
			end
			acc = 65'(win_sum[ch]) + 65'(sq);
			win_sum[ch] = (acc > 65'(SUM_LIMIT)) ? SUM_LIMIT : sum_t'(acc);
			history[ch][wr_ptr] = s;
			if (win_sum[ch] > win_max[ch]) begin
				win_max[ch] = win_sum[ch];
			end
			if (m > peak[ch]) begin
				peak[ch] = m;
			end
			acc = 65'(total[ch]) + 65'(sq);
			total[ch] = acc[64] ? '1 : acc[63:0];
		endfunction

		function void note_sample(sample_t l, sample_t r, logic rs);
			int unsigned w;
			int unsigned slot;
			bit          full;
			result_t     e;
			if (rs) begin
				clear();
			end
			w = 32'(win_len);
			if (w == 0) begin
				w = 1;
			end
			if (w > HIST_DEPTH) begin
				w = HIST_DEPTH;
			end
			if (wr_ptr >= HIST_DEPTH) begin
				wr_ptr = 0;
			end
			full = (fill >= w);
			slot = (wr_ptr >= w) ? wr_ptr - w : wr_ptr + HIST_DEPTH - w;
			update_channel(0, l, full, slot);
			update_channel(1, r, full, slot);
			fill = full ? w : fill + 1;
			wr_ptr = (wr_ptr + 1 >= HIST_DEPTH) ? 0 : wr_ptr + 1;
			if (count != '1) begin
				count++;
			end
			e.left.sum = win_sum[0];
			e.left.max = win_max[0];
			e.left.peak = peak[0];
			e.left.total = total[0];
			e.right.sum = win_sum[1];
			e.right.max = win_max[1];
			e.right.peak = peak[1];
			e.right.total = total[1];
			e.count = count;
			e.window_full = (fill >= w);
			pending = {pending, e};
		endfunction

		function void cmp(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				errors++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
				end
			end
		endfunction

		function void check_stats(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t ns: stats word with no sample outstanding", $time);
				return;
			end
			e = pending.pop_front();
			cmp("left_window_energy", 64'(e.left.sum), 64'(got.left.sum));
			cmp("right_window_energy", 64'(e.right.sum), 64'(got.right.sum));
			cmp("left_max_window_energy", 64'(e.left.max), 64'(got.left.max));
			cmp("right_max_window_energy", 64'(e.right.max), 64'(got.right.max));
			cmp("left_peak", 64'(e.left.peak), 64'(got.left.peak));
			cmp("right_peak", 64'(e.right.peak), 64'(got.right.peak));
			cmp("left_total_energy", e.left.total, got.left.total);
			cmp("right_total_energy", e.right.total, got.right.total);
			cmp("samples_seen", 64'(e.count), 64'(got.count));
			cmp("window_full", 64'(e.window_full), 64'(got.window_full));
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [WL_W-1:0] cfg_wdata;

	sswem_in_if  sample_bus ();
	sswem_out_if stats_bus ();

	stereo_sliding_window_energy_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (sample_bus),
		.stats     (stats_bus)
	);

	energy_scoreboard sb = new();
	result_t          stats_word;
	int               idle_cycles = 0;
	bit               hold_req = 1'b0;
	bit               quiet = 1'b0;
	bit               burst = 1'b0;
	int unsigned      phase_win [8] = '{2, 13, 1, 32768, 31, 5, 0, 48};

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1) begin
			sb.note_sample(sample_bus.left_sample, sample_bus.right_sample, sample_bus.restart);
			idle_cycles = 0;
		end else if (arst_n === 1'b1 && stats_bus.valid === 1'b1 && stats_bus.ready === 1'b1) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (arst_n === 1'b1 && stats_bus.valid === 1'b1 && stats_bus.ready === 1'b1) begin
			stats_word.left.sum = stats_bus.left_window_energy;
			stats_word.right.sum = stats_bus.right_window_energy;
			stats_word.left.max = stats_bus.left_max_window_energy;
			stats_word.right.max = stats_bus.right_max_window_energy;
			stats_word.left.peak = stats_bus.left_peak;
			stats_word.right.peak = stats_bus.right_peak;
			stats_word.left.total = stats_bus.left_total_energy;
			stats_word.right.total = stats_bus.right_total_energy;
			stats_word.count = stats_bus.samples_seen;
			stats_word.window_full = stats_bus.window_full;
			sb.check_stats(stats_word);
		end
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return sample_t'(int'($urandom_range(0, 16)) - 8);
			default: return sample_t'($urandom());
		endcase
	endfunction

	task automatic push_word(sample_t l, sample_t r, logic rs);
		int gap;
		gap = (quiet || burst) ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.left_sample <= l;
		sample_bus.right_sample <= r;
		sample_bus.restart <= rs;
		do @(posedge clk); while (sample_bus.ready !== 1'b1);
	endtask

	task automatic drain();
		@(negedge clk);
		sample_bus.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	task automatic set_window(logic [WL_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sb.set_window(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int low_left;
		low_left = 0;
		stats_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stats_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				stats_bus.ready <= 1'b1;
			end else if (low_left > 0) begin
				stats_bus.ready <= 1'b0;
				low_left--;
			end else begin
				stats_bus.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					low_left = pick_gap();
				end
			end
		end
	end

	initial begin
		int   n;
		logic rs;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.left_sample = '0;
		sample_bus.right_sample = '0;
		sample_bus.restart = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default window after reset
		push_word(MOST_POS, MOST_NEG, 1'b0);
		push_word(MOST_NEG, MOST_POS, 1'b0);
		push_word(24'sd0, 24'sd0, 1'b0);
		push_word(-24'sd1, 24'sd1, 1'b0);
		push_word(24'sd1, -24'sd1, 1'b1);

		set_window(16'd1);
		push_word(MOST_NEG, MOST_NEG, 1'b1);
		push_word(MOST_POS, 24'sd0, 1'b0);
		push_word(24'sd0, MOST_POS, 1'b0);
		push_word(24'sd5, -24'sd5, 1'b0);

		// zero length acts as one
		set_window(16'd0);
		push_word(24'sd3, -24'sd7, 1'b1);
		push_word(MOST_NEG, 24'sd2, 1'b0);
		push_word(24'sd0, 24'sd0, 1'b0);

		set_window(16'd3);
		push_word(MOST_POS, MOST_NEG, 1'b1);
		push_word(MOST_NEG, MOST_POS, 1'b0);
		push_word(24'sd100, -24'sd100, 1'b0);
		push_word(-24'sd4096, 24'sd4096, 1'b0);
		push_word(MOST_POS, MOST_POS, 1'b0);
		push_word(24'sd0, 24'sd0, 1'b0);

		// length changes with no restart: grow, then shrink below fill
		set_window(16'd5);
		push_word(MOST_NEG, 24'sd9, 1'b0);
		push_word(24'sd7, MOST_NEG, 1'b0);
		push_word(24'sd1, 24'sd1, 1'b0);
		push_word(MOST_POS, 24'sd0, 1'b0);
		set_window(16'd2);
		push_word(24'sd0, 24'sd0, 1'b0);
		push_word(24'sd2, -24'sd3, 1'b0);
		push_word(MOST_NEG, MOST_NEG, 1'b0);

		// above the depth, clamps to the depth
		set_window(16'hFFFF);
		push_word(MOST_NEG, MOST_POS, 1'b1);
		push_word(24'sd1, 24'sd1, 1'b0);

		for (int p = 0; p < 8; p++) begin
			set_window(phase_win[p][WL_W-1:0]);
			quiet = (p == 6);
			n = (phase_win[p] > 1000) ? 20 : 55;
			for (int i = 0; i < n; i++) begin
				if (p == 2 && i == 10) begin
					hold_req = 1'b1;
				end
				burst = (p == 2 && i >= 10 && i < 30);
				if (p == 5 && i == 25) begin
					drain();
				end
				rs = ((i == 0 && p != 4) || $urandom_range(0, 39) == 0);
				push_word(rand_sample(), rand_sample(), rs);
			end
			burst = 1'b0;
		end
		quiet = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
